[src/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared constants and types for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH   = 8;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VALUE_W = 32;
	localparam int OCC_W   = 4;
	localparam int STAT_W  = 2;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic   ins;
		logic   rem;
		value_t value;
	} spq_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		value_t            removed_value;
		logic [OCC_W-1:0]  occupancy;
	} spq_rsp_t;

endpackage

[src/spq_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one queue request.
// ----------------------------------------------------------------------------
interface spq_req_if;
	logic                valid;
	logic                ready;
	logic                kind;
	logic signed [31:0]  value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

[src/spq_rsp_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one queue result.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic signed [31:0]  removed_value;
	logic [3:0]          occupancy;

	modport source (output valid, output status, output removed_value, output occupancy,
		input ready);
	modport sink   (input valid, input status, input removed_value, input occupancy,
		output ready);
endinterface

[src/spq_cell.sv]
// ----------------------------------------------------------------------------
// Queue cell
// Holds one slot of the sorted row and exchanges entries with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic              clk,
	input  spq_pkg::spq_cmd_t cmd,
	input  logic              occupied,
	input  logic              left_le,
	input  spq_pkg::value_t   left_entry,
	input  spq_pkg::value_t   right_entry,
	output spq_pkg::value_t   entry,
	output logic              le
);
	import spq_pkg::*;

	value_t entry_q;
	logic   keep;

	// A held entry not above the new value stays; the first slot past those
	// takes the new value and the rest shift up by one.
	assign le    = occupied && ($signed(entry_q) <= $signed(cmd.value));
	assign keep  = le;
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (keep) begin
				entry_q <= entry_q;
			end else if (left_le) begin
				entry_q <= cmd.value;
			end else begin
				entry_q <= left_entry;
			end
		end else if (cmd.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

[src/sorted_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded minimum priority queue of signed 32-bit values in a row of cells.
// ----------------------------------------------------------------------------
// A request on req carries kind (insert or remove smallest) and value. Each
// accepted request produces exactly one result on rsp with status, the removed
// value and the occupancy after the request.
// All cells update together, so a request is accepted every cycle while
// req.ready is high, and its result is registered. The queue holds DEPTH
// entries in ascending order; inserting into a full queue or removing from
// an empty one leaves it unchanged and reports the condition in status.
// The result side has an output register and one skid register, so a request
// is still taken while one result waits. When both are full, req.ready drops
// until rsp.ready takes a result.
// Reset empties the queue and the result registers; entry contents are left
// as they are and are never read before being written.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
	input  logic clk,
	input  logic arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             main_valid_q;
	logic             skid_valid_q;
	spq_rsp_t         main_q;
	spq_rsp_t         skid_q;

	logic             push;
	logic             pop;
	logic             full;
	logic             empty;
	spq_cmd_t         cmd;
	spq_rsp_t         result;
	logic [CNT_W-1:0] count_next;

	value_t           cell_entry [DEPTH];
	logic             cell_le    [DEPTH];
	logic             cell_occ   [DEPTH];

	assign req.ready = !skid_valid_q;
	assign push      = req.valid && req.ready;
	assign pop       = rsp.valid && rsp.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	assign cmd.ins   = push && (req.kind == KIND_INSERT) && !full;
	assign cmd.rem   = push && (req.kind == KIND_REMOVE) && !empty;
	assign cmd.value = req.value;

	always_comb begin
		count_next = count_q;
		if (cmd.ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (cmd.rem) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		result.status        = ST_DONE;
		result.removed_value = '0;
		result.occupancy     = OCC_W'(count_next);
		if (req.kind == KIND_INSERT) begin
			if (full) begin
				result.status = ST_FULL;
			end
		end else if (empty) begin
			result.status = ST_EMPTY;
		end else begin
			result.removed_value = cell_entry[0];
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_occ[i] = (CNT_W'(i) < count_q);

		spq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (cell_occ[i]),
			.left_le     ((i == 0) ? 1'b1 : cell_le[(i == 0) ? 0 : i - 1]),
			.left_entry  (cell_entry[(i == 0) ? 0 : i - 1]),
			.right_entry (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
			.entry       (cell_entry[i]),
			.le          (cell_le[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : result;
		end else if (push) begin
			skid_q <= result;
		end
	end

	assign rsp.valid         = main_valid_q;
	assign rsp.status        = main_q.status;
	assign rsp.removed_value = main_q.removed_value;
	assign rsp.occupancy     = main_q.occupancy;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Entry count exceeds queue depth.");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("Skid register holds a result while the output register is empty.");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && (req.kind == KIND_INSERT) && !full |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("Accepted insert did not raise the entry count.");

	a_remove_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push && (req.kind == KIND_REMOVE) && empty |=> count_q == '0)
		else $error("Remove from an empty queue changed the entry count.");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> main_valid_q)
		else $error("Accepted request left no result in the output register.");
`endif

endmodule
